/* hdl/distance_activity_tracker_core_assert.svh */
// Assertion macros for the distance activity tracker.
// Concurrent checks are compiled for simulation only; synthesis sees empty bodies.
// Used by distance_activity_tracker_core.sv.
`ifndef DISTANCE_ACTIVITY_TRACKER_CORE_ASSERT_SVH
`define DISTANCE_ACTIVITY_TRACKER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define DAT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DAT_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define DAT_ASSERT(lbl, clk, rst_n, prop, msg)
`define DAT_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

/* hdl/dat_pkg.sv */
// Shared types and constants of the distance activity tracker.
// No dependencies; used by the interfaces and every module of the block.
`default_nettype none

package dat_pkg;

  // Channel and field widths.
  localparam int unsigned NumSensors = 4;
  localparam int unsigned SensorIdxW = 2;
  localparam int unsigned DistW      = 16;
  localparam int unsigned TimeW      = 32;
  localparam int unsigned CvW        = 7;
  localparam int unsigned CcnW       = 7;
  localparam int unsigned SpeedW     = 8;
  localparam int unsigned PhaseW     = 16;
  localparam int unsigned ClampW     = 11;

  // Configuration port.
  localparam int unsigned PaddrW   = 5;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned RegIdxW  = 3;

  typedef enum logic [RegIdxW-1:0] {
    RegActThr      = 3'd0,
    RegQuietLimit  = 3'd1,
    RegCcThr       = 3'd2,
    RegIdleStep    = 3'd3,
    RegCcBase      = 3'd4
  } dat_reg_e;

  // Mapping constants.
  localparam int unsigned DistLo   = 50;
  localparam int unsigned DistHi   = 1200;
  localparam int unsigned DistMid  = 300;
  localparam int unsigned SpeedLo  = 20;
  localparam int unsigned SpeedMid = 100;
  localparam int unsigned SpeedHi  = 250;
  localparam int unsigned CvMax    = 127;

  // Division by constants as multiplication by a rounded-up reciprocal.
  // Each shift is large enough that the rounding error never reaches one
  // unit over the input range, so the truncated quotient is exact.
  localparam int unsigned CvShift  = 28;
  localparam int unsigned CvMulW   = 25;
  localparam int unsigned CvProdW  = ClampW + CvMulW;
  localparam logic [CvMulW-1:0] CvMul =
    CvMulW'(CvMax * ((1 << CvShift) / (DistHi - DistLo) + 1));

  localparam int unsigned SpdLoShift = 24;
  localparam int unsigned SpdLoXW    = 8;
  localparam int unsigned SpdLoMulW  = 23;
  localparam int unsigned SpdLoProdW = SpdLoXW + SpdLoMulW;
  localparam logic [SpdLoMulW-1:0] SpdLoMul =
    SpdLoMulW'((SpeedMid - SpeedLo) * ((1 << SpdLoShift) / (DistMid - DistLo) + 1));

  localparam int unsigned SpdHiShift = 28;
  localparam int unsigned SpdHiXW    = 10;
  localparam int unsigned SpdHiMulW  = 26;
  localparam int unsigned SpdHiProdW = SpdHiXW + SpdHiMulW;
  localparam logic [SpdHiMulW-1:0] SpdHiMul =
    SpdHiMulW'((SpeedHi - SpeedMid) * ((1 << SpdHiShift) / (DistHi - DistMid) + 1));

  // Register reset values.
  localparam logic [7:0]  ActThrRst      = 8'd3;
  localparam logic [15:0] QuietLimitRst  = 16'd2000;
  localparam logic [6:0]  CcThrRst       = 7'd3;
  localparam logic [7:0]  IdleStepRst    = 8'd10;
  localparam logic [6:0]  CcBaseRst      = 7'd10;

  typedef struct packed {
    logic [7:0]  act_thr;
    logic [15:0] quiet_limit;
    logic [6:0]  cc_thr;
    logic [7:0]  idle_step;
    logic [6:0]  cc_base;
  } dat_cfg_t;

  // One sample with its input-only mappings already worked out.
  typedef struct packed {
    logic [SensorIdxW-1:0] idx;
    logic [DistW-1:0]      distance;
    logic [TimeW-1:0]      now;
    logic [CvW-1:0]        cv;
    logic [SpeedW-1:0]     speed;
  } dat_item_t;

  // Per-sensor state, one memory word.
  typedef struct packed {
    logic [DistW-1:0]  prev_dist;
    logic              active;
    logic [TimeW-1:0]  act_time;
    logic [SpeedW-1:0] speed;
    logic [PhaseW-1:0] phase;
    logic [CvW-1:0]    last_sent;
  } dat_state_t;

  typedef struct packed {
    logic [CvW-1:0]    control_value;
    logic              send_control;
    logic [CcnW-1:0]   controller_number;
    logic              channel_active;
    logic [SpeedW-1:0] animation_speed;
    logic [PhaseW-1:0] animation_phase;
  } dat_result_t;

endpackage

`default_nettype wire

/* hdl/dat_stream_if.sv */
// Valid/ready stream interfaces for samples and results.
// Depends on dat_pkg for the field widths.
`default_nettype none

interface dat_in_if;
  logic                            valid;
  logic                            ready;
  logic [dat_pkg::SensorIdxW-1:0]  sensor_index;
  logic [dat_pkg::DistW-1:0]       distance_mm;
  logic [dat_pkg::TimeW-1:0]       time_ms;

  modport source (output valid, sensor_index, distance_mm, time_ms, input ready);
  modport sink   (input valid, sensor_index, distance_mm, time_ms, output ready);
endinterface

interface dat_out_if;
  logic                        valid;
  logic                        ready;
  logic [dat_pkg::CvW-1:0]     control_value;
  logic                        send_control;
  logic [dat_pkg::CcnW-1:0]    controller_number;
  logic                        channel_active;
  logic [dat_pkg::SpeedW-1:0]  animation_speed;
  logic [dat_pkg::PhaseW-1:0]  animation_phase;

  modport source (output valid, control_value, send_control, controller_number,
                  channel_active, animation_speed, animation_phase, input ready);
  modport sink   (input valid, control_value, send_control, controller_number,
                  channel_active, animation_speed, animation_phase, output ready);
endinterface

`default_nettype wire

/* hdl/distance_activity_tracker_core.sv */
// Distance activity tracker: per-sensor control value and activity tracking.
// Depends on dat_pkg, dat_stream_if, dat_cfg_regs, dat_update and the assertion header.
//
//   Channel   Direction  Handshake              Carries
//   in_i      sink       valid/ready            sensor_index, distance_mm, time_ms
//   out_o     source     valid/ready            control value, flags, speed, phase
//   APB       slave      psel/penable/pready    five configuration registers
//
// One transaction is accepted per cycle while the output is not stalled; its result
// passes through a memory-read stage and an update stage feeding the output register.
// The state memory has one read port and one write port, so a read and a write-back
// can take place in the same cycle.
// Reset clears the pipeline and output valid flags and the entry valid bits; an entry
// never written reads as all zero, so no clearing pass is needed.
// When the output is stalled the update stage holds and the input stops taking new
// transactions until the held result can move into the output register.
`default_nettype none

`include "distance_activity_tracker_core_assert.svh"

module distance_activity_tracker_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  dat_in_if.sink                             in_i,
  dat_out_if.source                          out_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [dat_pkg::PaddrW-1:0]    paddr,
  input  wire logic [dat_pkg::ApbDataW-1:0]  pwdata,
  output logic      [dat_pkg::ApbDataW-1:0]  prdata,
  output logic                               pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  dat_pkg::dat_cfg_t cfg;

  dat_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // ---------------------------------------------------------------------------
  // Pipeline control
  // ---------------------------------------------------------------------------
  // The update stage advances when the output register is empty or being
  // drained this cycle; the input is taken whenever the update stage will be
  // free at the next edge.
  logic s1_valid_q;
  logic s1_adv;
  logic in_ready;
  logic in_acc;
  logic out_valid_q;

  assign s1_adv   = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_ready = !s1_valid_q || s1_adv;
  assign in_acc   = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  // ---------------------------------------------------------------------------
  // Input-only mappings, computed in the acceptance cycle
  // ---------------------------------------------------------------------------
  // The distance is clamped first; the control value and the activity speed
  // depend on the sample alone and are registered alongside it, so the update
  // stage only has compares, differences and adds.
  logic [dat_pkg::ClampW-1:0]     clamped;
  logic [dat_pkg::ClampW-1:0]     cv_x;
  logic [dat_pkg::CvProdW-1:0]    cv_prod;
  logic                           below_mid;
  logic [dat_pkg::SpdLoXW-1:0]    lo_x;
  logic [dat_pkg::SpdLoProdW-1:0] lo_prod;
  logic [dat_pkg::SpdHiXW-1:0]    hi_x;
  logic [dat_pkg::SpdHiProdW-1:0] hi_prod;
  logic [dat_pkg::SpeedW-1:0]     spd_lo;
  logic [dat_pkg::SpeedW-1:0]     spd_hi;
  dat_pkg::dat_item_t             item_d;

  always_comb begin
    priority if (in_i.distance_mm < dat_pkg::DistW'(dat_pkg::DistLo)) begin
      clamped = dat_pkg::ClampW'(dat_pkg::DistLo);
    end else if (in_i.distance_mm > dat_pkg::DistW'(dat_pkg::DistHi)) begin
      clamped = dat_pkg::ClampW'(dat_pkg::DistHi);
    end else begin
      clamped = in_i.distance_mm[dat_pkg::ClampW-1:0];
    end
  end

  // Scaling of the clamped range onto 0..127, truncated.
  assign cv_x    = clamped - dat_pkg::ClampW'(dat_pkg::DistLo);
  assign cv_prod = dat_pkg::CvProdW'(cv_x) * dat_pkg::CvProdW'(dat_pkg::CvMul);

  // Speed: a steep segment below the mid distance and a shallow one above it.
  assign below_mid = clamped < dat_pkg::ClampW'(dat_pkg::DistMid);
  assign lo_x      = dat_pkg::SpdLoXW'(clamped - dat_pkg::ClampW'(dat_pkg::DistLo));
  assign hi_x      = dat_pkg::SpdHiXW'(clamped - dat_pkg::ClampW'(dat_pkg::DistMid));
  assign lo_prod   = dat_pkg::SpdLoProdW'(lo_x) * dat_pkg::SpdLoProdW'(dat_pkg::SpdLoMul);
  assign hi_prod   = dat_pkg::SpdHiProdW'(hi_x) * dat_pkg::SpdHiProdW'(dat_pkg::SpdHiMul);
  assign spd_lo    = lo_prod[dat_pkg::SpdLoShift +: dat_pkg::SpeedW]
                   + dat_pkg::SpeedW'(dat_pkg::SpeedLo);
  assign spd_hi    = hi_prod[dat_pkg::SpdHiShift +: dat_pkg::SpeedW]
                   + dat_pkg::SpeedW'(dat_pkg::SpeedMid);

  always_comb begin
    item_d.idx      = in_i.sensor_index;
    item_d.distance = in_i.distance_mm;
    item_d.now      = in_i.time_ms;
    item_d.cv       = cv_prod[dat_pkg::CvShift +: dat_pkg::CvW];
    item_d.speed    = below_mid ? spd_lo : spd_hi;
  end

  // ---------------------------------------------------------------------------
  // State memory with valid bits and write-to-read forwarding
  // ---------------------------------------------------------------------------
  // The read for a new transaction is issued at its acceptance edge, the same
  // edge at which the previous transaction writes its updated word back.  When
  // both address the same sensor the memory would return the old word, so the
  // word being written is captured and used instead.
  dat_pkg::dat_state_t            mem_q [dat_pkg::NumSensors];
  dat_pkg::dat_state_t            rd_data_q;
  logic [dat_pkg::NumSensors-1:0] valid_q;
  logic                           rd_valid_q;
  logic                           fwd_q;
  dat_pkg::dat_state_t            fwd_data_q;
  dat_pkg::dat_item_t             s1_item_q;
  dat_pkg::dat_state_t            cur_state;
  dat_pkg::dat_state_t            upd_state;
  logic                           upd_we;
  logic                           mem_we;
  logic [dat_pkg::SensorIdxW-1:0] wr_addr;
  logic                           fwd_d;
  dat_pkg::dat_result_t           res;
  dat_pkg::dat_result_t           out_data_q;
  logic                           active_slow;

  assign wr_addr = s1_item_q.idx;
  assign mem_we  = s1_adv && upd_we;
  assign fwd_d   = mem_we && (wr_addr == in_i.sensor_index);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= upd_state;
    end
    if (in_acc) begin
      rd_data_q  <= mem_q[in_i.sensor_index];
      fwd_data_q <= upd_state;
      s1_item_q  <= item_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      if (mem_we) begin
        valid_q[wr_addr] <= 1'b1;
      end
      if (in_acc) begin
        rd_valid_q <= valid_q[in_i.sensor_index];
        fwd_q      <= fwd_d;
      end
    end
  end

  always_comb begin
    priority if (fwd_q) begin
      cur_state = fwd_data_q;
    end else if (rd_valid_q) begin
      cur_state = rd_data_q;
    end else begin
      cur_state = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Update stage
  // ---------------------------------------------------------------------------
  dat_update u_update (
    .item_i   (s1_item_q),
    .state_i  (cur_state),
    .cfg_i    (cfg),
    .state_o  (upd_state),
    .we_o     (upd_we),
    .result_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_data_q <= res;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  assign out_o.valid             = out_valid_q;
  assign out_o.control_value     = out_data_q.control_value;
  assign out_o.send_control      = out_data_q.send_control;
  assign out_o.controller_number = out_data_q.controller_number;
  assign out_o.channel_active    = out_data_q.channel_active;
  assign out_o.animation_speed   = out_data_q.animation_speed;
  assign out_o.animation_phase   = out_data_q.animation_phase;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // An active channel always carries a speed set by activity, never below the minimum.
  assign active_slow = res.channel_active
                     && (res.animation_speed < dat_pkg::SpeedW'(dat_pkg::SpeedLo));

  `DAT_ASSERT(a_fwd_capture, clk_i, rst_ni, (in_acc && fwd_d) |=> fwd_q, "missed forwarding")
  `DAT_ASSERT(a_valid_after_write, clk_i, rst_ni, mem_we |=> valid_q[$past(wr_addr)], "no valid")
  `DAT_ASSERT_NEVER(a_active_speed, clk_i, rst_ni, s1_adv && active_slow, "speed too low")

endmodule

`default_nettype wire

/* hdl/dat_cfg_regs.sv */
// APB-style configuration registers of the distance activity tracker.
// Depends on dat_pkg for the register map and the configuration struct.
`default_nettype none

module dat_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [dat_pkg::PaddrW-1:0]    paddr,
  input  wire logic [dat_pkg::ApbDataW-1:0]  pwdata,
  output logic      [dat_pkg::ApbDataW-1:0]  prdata,
  output logic                               pready,
  output dat_pkg::dat_cfg_t                  cfg_o
);

  dat_pkg::dat_cfg_t                 cfg_q;
  logic                              wr_en;
  logic [dat_pkg::RegIdxW-1:0]       reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[dat_pkg::PaddrW-1:2];
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.act_thr      <= dat_pkg::ActThrRst;
      cfg_q.quiet_limit  <= dat_pkg::QuietLimitRst;
      cfg_q.cc_thr       <= dat_pkg::CcThrRst;
      cfg_q.idle_step    <= dat_pkg::IdleStepRst;
      cfg_q.cc_base      <= dat_pkg::CcBaseRst;
    end else if (wr_en) begin
      unique case (reg_idx)
        dat_pkg::RegActThr:      cfg_q.act_thr      <= pwdata[7:0];
        dat_pkg::RegQuietLimit:  cfg_q.quiet_limit  <= pwdata[15:0];
        dat_pkg::RegCcThr:       cfg_q.cc_thr       <= pwdata[6:0];
        dat_pkg::RegIdleStep:    cfg_q.idle_step    <= pwdata[7:0];
        dat_pkg::RegCcBase:      cfg_q.cc_base      <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      dat_pkg::RegActThr:      prdata = dat_pkg::ApbDataW'(cfg_q.act_thr);
      dat_pkg::RegQuietLimit:  prdata = dat_pkg::ApbDataW'(cfg_q.quiet_limit);
      dat_pkg::RegCcThr:       prdata = dat_pkg::ApbDataW'(cfg_q.cc_thr);
      dat_pkg::RegIdleStep:    prdata = dat_pkg::ApbDataW'(cfg_q.idle_step);
      dat_pkg::RegCcBase:      prdata = dat_pkg::ApbDataW'(cfg_q.cc_base);
      default:                 prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* hdl/dat_update.sv */
// Read-modify-write update of one sensor's state word.
// Depends on dat_pkg for the item, state, configuration and result types.
`default_nettype none

module dat_update (
  input  wire dat_pkg::dat_item_t    item_i,
  input  wire dat_pkg::dat_state_t   state_i,
  input  wire dat_pkg::dat_cfg_t     cfg_i,
  output dat_pkg::dat_state_t        state_o,
  output logic                       we_o,
  output dat_pkg::dat_result_t       result_o
);

  logic                          in_range;
  logic [dat_pkg::CvW-1:0]       cv_diff;
  logic                          send;
  logic [dat_pkg::DistW-1:0]     dist_diff;
  logic                          activity;
  logic [dat_pkg::TimeW-1:0]     elapsed;
  logic                          timed_out;
  logic [dat_pkg::SpeedW-1:0]    step;
  dat_pkg::dat_state_t           nxt;

  assign in_range = {1'b0, item_i.idx} < (dat_pkg::SensorIdxW + 1)'(dat_pkg::NumSensors);

  assign cv_diff  = (item_i.cv >= state_i.last_sent) ? item_i.cv - state_i.last_sent
                                                      : state_i.last_sent - item_i.cv;
  assign send     = cv_diff > cfg_i.cc_thr;

  assign dist_diff = (item_i.distance >= state_i.prev_dist)
                   ? item_i.distance - state_i.prev_dist
                   : state_i.prev_dist - item_i.distance;
  assign activity  = dist_diff > dat_pkg::DistW'(cfg_i.act_thr);

  // Wrapping subtraction keeps the timeout correct across a timestamp rollover.
  assign elapsed   = item_i.now - state_i.act_time;
  assign timed_out = state_i.active && (elapsed > dat_pkg::TimeW'(cfg_i.quiet_limit));

  always_comb begin
    nxt           = state_i;
    nxt.prev_dist = item_i.distance;
    if (send) begin
      nxt.last_sent = item_i.cv;
    end
    priority if (activity) begin
      nxt.active   = 1'b1;
      nxt.act_time = item_i.now;
      nxt.speed    = item_i.speed;
    end else if (timed_out) begin
      nxt.active = 1'b0;
    end else begin
      nxt.active = state_i.active;
    end
    step      = nxt.active ? nxt.speed : cfg_i.idle_step;
    nxt.phase = state_i.phase + dat_pkg::PhaseW'(step);
  end

  assign state_o = nxt;
  assign we_o    = in_range;

  always_comb begin
    result_o.control_value     = item_i.cv;
    result_o.controller_number = cfg_i.cc_base + dat_pkg::CcnW'(item_i.idx);
    result_o.send_control      = in_range & send;
    result_o.channel_active    = in_range & nxt.active;
    result_o.animation_speed   = in_range ? nxt.speed : '0;
    result_o.animation_phase   = in_range ? nxt.phase : '0;
  end

endmodule

`default_nettype wire

/* test/tb_distance_activity_tracker_core.sv */
`timescale 1ns / 1ps
// Self-checking testbench of distance_activity_tracker_core: directed and random samples.
// Depends on dat_pkg, the stream interfaces in dat_stream_if and the tracker RTL.
module tb_distance_activity_tracker_core;

  // Run length and pacing.
  localparam int unsigned CycleLimit    = 200_000;
  localparam int unsigned SettleCycles  = 6;
  localparam int unsigned ResetCycles   = 4;
  localparam int unsigned ItemsPerPhase = 105;
  localparam int unsigned NumPhases     = 6;
  localparam int unsigned RegStride     = 4;
  localparam int unsigned CcBaseMax     = 123;

  // Register indexes that decode to nothing; writes there must be ignored.
  localparam int unsigned FirstUnusedReg = 5;
  localparam int unsigned LastUnusedReg  = 7;

  typedef struct packed {
    logic [dat_pkg::SensorIdxW-1:0] sensor;
    logic [dat_pkg::DistW-1:0]      distance;
    logic [dat_pkg::TimeW-1:0]      now;
  } sample_t;

  // A directed row carries its expected result only where it is obvious by hand;
  // the other rows are checked against the predictor below.
  typedef struct packed {
    sample_t              sample;
    logic                 typed;
    dat_pkg::dat_result_t result;
  } directed_row_t;

  localparam directed_row_t DirectedRows [20] = '{
    // Reset state everywhere: no activity, the idle step alone moves the phase.
    '{'{2'd0, 16'd0, 32'd0}, 1'b1, '{7'd0, 1'b0, 7'd10, 1'b0, 8'd0, 16'd10}},
    // Largest distance: clamped to the top, full control value and top speed.
    '{'{2'd1, 16'd65535, 32'd0}, 1'b1, '{7'd127, 1'b1, 7'd11, 1'b1, 8'd250, 16'd250}},
    // Bottom of the clamp range: slowest speed.
    '{'{2'd2, 16'd50, 32'd0}, 1'b1, '{7'd0, 1'b0, 7'd12, 1'b1, 8'd20, 16'd20}},
    '{'{2'd3, 16'd1200, 32'hFFFF_FFFF}, 1'b1,
      '{7'd127, 1'b1, 7'd13, 1'b1, 8'd250, 16'd250}},
    // Elapsed time equal to the timeout keeps the channel active, one more drops it.
    '{'{2'd1, 16'd65535, 32'd2000}, 1'b0, '0},
    '{'{2'd1, 16'd65535, 32'd2001}, 1'b0, '0},
    // Timestamp wrapping past zero: the elapsed time is taken modulo 2^32.
    '{'{2'd3, 16'd1200, 32'd5}, 1'b0, '0},
    '{'{2'd3, 16'd1200, 32'd2000}, 1'b0, '0},
    // A change equal to the activity threshold is not activity.
    '{'{2'd0, 16'd3, 32'd10}, 1'b0, '0},
    '{'{2'd0, 16'd7, 32'd20}, 1'b0, '0},
    // Either side of the speed knee.
    '{'{2'd2, 16'd299, 32'd30}, 1'b0, '0},
    '{'{2'd2, 16'd300, 32'd40}, 1'b0, '0},
    '{'{2'd2, 16'd301, 32'd50}, 1'b0, '0},
    '{'{2'd0, 16'd49, 32'd60}, 1'b0, '0},
    '{'{2'd0, 16'd51, 32'd70}, 1'b0, '0},
    '{'{2'd1, 16'd1199, 32'd80}, 1'b0, '0},
    '{'{2'd1, 16'd1201, 32'd90}, 1'b0, '0},
    '{'{2'd0, 16'd625, 32'd100}, 1'b0, '0},
    // Small control value change: no message.
    '{'{2'd2, 16'd304, 32'd110}, 1'b0, '0},
    '{'{2'd3, 16'd4, 32'h8000_0000}, 1'b0, '0}
  };

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [dat_pkg::PaddrW-1:0]   paddr;
  logic [dat_pkg::ApbDataW-1:0] pwdata;
  logic [dat_pkg::ApbDataW-1:0] prdata;
  logic                         pready;

  dat_in_if  sample_if ();
  dat_out_if result_if ();

  distance_activity_tracker_core i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (sample_if),
    .out_o   (result_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor: the testbench's own copy of the configuration and per-sensor state.
  dat_pkg::dat_cfg_t          cfg;
  logic [dat_pkg::DistW-1:0]  sensor_prev_dist [dat_pkg::NumSensors];
  logic                       sensor_active    [dat_pkg::NumSensors];
  logic [dat_pkg::TimeW-1:0]  sensor_act_time  [dat_pkg::NumSensors];
  logic [dat_pkg::SpeedW-1:0] sensor_speed     [dat_pkg::NumSensors];
  logic [dat_pkg::PhaseW-1:0] sensor_phase     [dat_pkg::NumSensors];
  logic [dat_pkg::CvW-1:0]    sensor_last_sent [dat_pkg::NumSensors];

  dat_pkg::dat_result_t expected_results [$];
  int unsigned          error_count;

  // Stimulus-side bookkeeping, kept apart from the predictor.
  logic [dat_pkg::TimeW-1:0] stim_clock;
  logic [dat_pkg::DistW-1:0] stim_last_dist [dat_pkg::NumSensors];
  int unsigned               burst_left;
  int unsigned               sender_max_gap;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned distance_between(input int unsigned a, input int unsigned b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Works out the result of one sample and advances the sensor's state.
  function automatic dat_pkg::dat_result_t track_sample(input sample_t s);
    dat_pkg::dat_result_t      r;
    int unsigned               clamped;
    int unsigned               level;
    logic [dat_pkg::TimeW-1:0] elapsed;
    clamped = s.distance;
    if (clamped < dat_pkg::DistLo) clamped = dat_pkg::DistLo;
    else if (clamped > dat_pkg::DistHi) clamped = dat_pkg::DistHi;
    level = (clamped - dat_pkg::DistLo) * dat_pkg::CvMax / (dat_pkg::DistHi - dat_pkg::DistLo);

    r.control_value     = dat_pkg::CvW'(level);
    r.controller_number = dat_pkg::CcnW'(cfg.cc_base + s.sensor);
    r.send_control      = 1'b0;
    if (distance_between(level, sensor_last_sent[s.sensor]) > cfg.cc_thr) begin
      r.send_control             = 1'b1;
      sensor_last_sent[s.sensor] = dat_pkg::CvW'(level);
    end

    // Activity is judged on the raw distance, the speed on the clamped one.
    if (distance_between(s.distance, sensor_prev_dist[s.sensor]) > cfg.act_thr) begin
      sensor_active[s.sensor]   = 1'b1;
      sensor_act_time[s.sensor] = s.now;
      if (clamped < dat_pkg::DistMid) begin
        sensor_speed[s.sensor] = dat_pkg::SpeedW'(
          (clamped - dat_pkg::DistLo) * (dat_pkg::SpeedMid - dat_pkg::SpeedLo) /
          (dat_pkg::DistMid - dat_pkg::DistLo) + dat_pkg::SpeedLo);
      end else begin
        sensor_speed[s.sensor] = dat_pkg::SpeedW'(
          (clamped - dat_pkg::DistMid) * (dat_pkg::SpeedHi - dat_pkg::SpeedMid) /
          (dat_pkg::DistHi - dat_pkg::DistMid) + dat_pkg::SpeedMid);
      end
    end else begin
      elapsed = s.now - sensor_act_time[s.sensor];
      if (sensor_active[s.sensor] && elapsed > cfg.quiet_limit) begin
        sensor_active[s.sensor] = 1'b0;
      end
    end
    sensor_prev_dist[s.sensor] = s.distance;
    sensor_phase[s.sensor] = sensor_phase[s.sensor] +
      (sensor_active[s.sensor] ? sensor_speed[s.sensor] : cfg.idle_step);

    r.channel_active  = sensor_active[s.sensor];
    r.animation_speed = sensor_speed[s.sensor];
    r.animation_phase = sensor_phase[s.sensor];
    return r;
  endfunction

  // Random samples are mostly a plausible stream: time moving forward a little,
  // distances held or nudged around the activity threshold, with pauses around the
  // idle timeout. The rest are jumps in time and distances anywhere in range.
  function automatic sample_t next_random_sample();
    sample_t     s;
    int unsigned pick;
    int          margin;
    int          probe;
    s.sensor = dat_pkg::SensorIdxW'($urandom_range(dat_pkg::NumSensors - 1));
    pick = $urandom_range(99);
    if (pick < 70) begin
      stim_clock = stim_clock + $urandom_range(40);
    end else if (pick < 85) begin
      stim_clock = stim_clock + cfg.quiet_limit + $urandom_range(2);
    end else if (pick < 95) begin
      stim_clock = stim_clock + $urandom_range(100_000);
    end else begin
      stim_clock = $urandom;
    end
    s.now = stim_clock;

    pick = $urandom_range(99);
    if (pick < 30) begin
      s.distance = stim_last_dist[s.sensor];
    end else if (pick < 55) begin
      margin = int'(cfg.act_thr) + 2;
      probe  = int'(stim_last_dist[s.sensor]) + int'($urandom_range(2 * margin)) - margin;
      if (probe < 0) probe = 0;
      else if (probe > 65535) probe = 65535;
      s.distance = dat_pkg::DistW'(probe);
    end else if (pick < 85) begin
      s.distance = dat_pkg::DistW'($urandom_range(dat_pkg::DistHi + 200));
    end else if (pick < 95) begin
      case ($urandom_range(4))
        0:       s.distance = '0;
        1:       s.distance = '1;
        2:       s.distance = dat_pkg::DistW'(dat_pkg::DistLo - 1 + $urandom_range(2));
        3:       s.distance = dat_pkg::DistW'(dat_pkg::DistMid - 1 + $urandom_range(2));
        default: s.distance = dat_pkg::DistW'(dat_pkg::DistHi - 1 + $urandom_range(2));
      endcase
    end else begin
      s.distance = dat_pkg::DistW'($urandom);
    end
    return s;
  endfunction

  // Offers one sample, possibly after an idle gap, and books its expected result
  // once the transaction has been accepted.
  task automatic send_sample(input sample_t s, input logic typed,
                             input dat_pkg::dat_result_t typed_result);
    dat_pkg::dat_result_t predicted;
    int unsigned          gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (sender_max_gap == 0) ? 0 : $urandom_range(sender_max_gap);
      if (gap != 0) begin
        sample_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    sample_if.valid        <= 1'b1;
    sample_if.sensor_index <= s.sensor;
    sample_if.distance_mm  <= s.distance;
    sample_if.time_ms      <= s.now;
    @(posedge clk_i);
    while (!sample_if.ready) @(posedge clk_i);
    predicted = track_sample(s);
    expected_results.push_back(typed ? typed_result : predicted);
    stim_last_dist[s.sensor] = s.distance;
  endtask

  // Stops offering samples and waits until every result is back and the
  // pipeline has had time to empty.
  task automatic settle();
    sample_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // One APB write: setup cycle, then access cycle until pready.
  task automatic write_register(input int unsigned index,
                                input logic [dat_pkg::ApbDataW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= dat_pkg::PaddrW'(index * RegStride);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (index)
      dat_pkg::RegActThr:     cfg.act_thr     = value[7:0];
      dat_pkg::RegQuietLimit: cfg.quiet_limit = value[15:0];
      dat_pkg::RegCcThr:      cfg.cc_thr      = value[6:0];
      dat_pkg::RegIdleStep:   cfg.idle_step   = value[7:0];
      dat_pkg::RegCcBase:     cfg.cc_base     = value[6:0];
      default: ;
    endcase
  endtask

  // Writes every register, with random bits above each register's width, and
  // finishes with a write to an address that decodes to no register.
  task automatic apply_settings(input dat_pkg::dat_cfg_t setting);
    write_register(dat_pkg::RegActThr,     32'({$urandom, setting.act_thr}));
    write_register(dat_pkg::RegQuietLimit, 32'({$urandom, setting.quiet_limit}));
    write_register(dat_pkg::RegCcThr,      32'({$urandom, setting.cc_thr}));
    write_register(dat_pkg::RegIdleStep,   32'({$urandom, setting.idle_step}));
    write_register(dat_pkg::RegCcBase,     32'({$urandom, setting.cc_base}));
    write_register($urandom_range(FirstUnusedReg, LastUnusedReg), $urandom);
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  // Every result transaction is matched against the oldest outstanding expectation.
  always @(posedge clk_i) begin : check_results
    dat_pkg::dat_result_t oldest;
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (expected_results.size() == 0) begin
        $error("result transaction with no sample outstanding");
        error_count++;
      end else begin
        oldest = expected_results.pop_front();
        check_field("control_value", oldest.control_value, result_if.control_value);
        check_field("send_control", oldest.send_control, result_if.send_control);
        check_field("controller_number", oldest.controller_number,
                    result_if.controller_number);
        check_field("channel_active", oldest.channel_active, result_if.channel_active);
        check_field("animation_speed", oldest.animation_speed, result_if.animation_speed);
        check_field("animation_phase", oldest.animation_phase, result_if.animation_phase);
      end
    end
  end

  // The receiver stalls on a rotating pattern that is replaced by a new random one
  // when its age runs out; some patterns are all ones, which gives stretches with no stall.
  initial begin : result_receiver
    logic [15:0] stall_pattern;
    int unsigned pattern_age;
    result_if.ready = 1'b0;
    stall_pattern   = '1;
    pattern_age     = 0;
    forever begin
      @(posedge clk_i);
      if (pattern_age == 0) begin
        pattern_age = $urandom_range(32, 96);
        case ($urandom_range(2))
          0:       stall_pattern = '1;
          1:       stall_pattern = 16'($urandom) | 16'h8001;
          default: stall_pattern = 16'($urandom & $urandom) | 16'h0001;
        endcase
      end
      pattern_age--;
      stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
      result_if.ready <= stall_pattern[0];
    end
  end

  initial begin : watchdog
    int unsigned cycle_count;
    for (cycle_count = 0; cycle_count < CycleLimit; cycle_count++) @(posedge clk_i);
    $display("** distance_activity_tracker_core: FAILED **");
    $finish;
  end

  initial begin : stimulus
    dat_pkg::dat_cfg_t plan [NumPhases];
    rst_ni                 = 1'b0;
    sample_if.valid        = 1'b0;
    sample_if.sensor_index = '0;
    sample_if.distance_mm  = '0;
    sample_if.time_ms      = '0;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    error_count            = 0;
    burst_left             = 0;
    sender_max_gap         = 3;
    stim_clock             = '0;
    cfg = '{dat_pkg::ActThrRst, dat_pkg::QuietLimitRst, dat_pkg::CcThrRst,
            dat_pkg::IdleStepRst, dat_pkg::CcBaseRst};
    for (int i = 0; i < dat_pkg::NumSensors; i++) begin
      sensor_prev_dist[i] = '0;
      sensor_active[i]    = 1'b0;
      sensor_act_time[i]  = '0;
      sensor_speed[i]     = '0;
      sensor_phase[i]     = '0;
      sensor_last_sent[i] = '0;
      stim_last_dist[i]   = '0;
    end

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed samples run on the reset configuration.
    for (int i = 0; i < $size(DirectedRows); i++) begin
      send_sample(DirectedRows[i].sample, DirectedRows[i].typed, DirectedRows[i].result);
    end
    settle();

    // Configurations: reset values, all minima, all maxima, a controller base that
    // wraps past 127, and two random ones.
    plan[0] = '{dat_pkg::ActThrRst, dat_pkg::QuietLimitRst, dat_pkg::CcThrRst,
                dat_pkg::IdleStepRst, dat_pkg::CcBaseRst};
    plan[1] = '{8'd0, 16'd0, 7'd0, 8'd0, 7'd0};
    plan[2] = '{8'd255, 16'd65535, 7'd127, 8'd255, 7'(CcBaseMax)};
    plan[3] = '{8'($urandom_range(8)), 16'($urandom_range(50, 3000)),
                7'($urandom_range(10)), 8'($urandom), 7'h7F};
    plan[4] = '{8'($urandom), 16'($urandom), 7'($urandom), 8'($urandom),
                7'($urandom_range(CcBaseMax))};
    plan[5] = '{8'($urandom_range(16)), 16'($urandom_range(500)),
                7'($urandom_range(16)), 8'($urandom), 7'($urandom_range(CcBaseMax))};

    for (int p = 0; p < NumPhases; p++) begin
      apply_settings(plan[p]);
      // The all-minima phase runs the sender flat out.
      sender_max_gap = (p == 1) ? 0 : $urandom_range(1, 8);
      repeat (ItemsPerPhase) send_sample(next_random_sample(), 1'b0, '0);
      settle();
    end

    if (error_count == 0) begin
      $display("** distance_activity_tracker_core: PASSED **");
    end else begin
      $display("** distance_activity_tracker_core: FAILED **");
    end
    $finish;
  end

endmodule
